>>> rtl/cubic_bezier_point_evaluator_macros.svh
// Assertion macros used by the cubic Bezier evaluator top level.
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_MACROS_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_MACROS_SVH

// Implication checked in the same cycle, sampled on clk_i, off during reset.
`define CBPE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, sampled on clk_i, off during reset.
`define CBPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cbpe_pkg.sv
// Shared constants for the cubic Bezier point evaluator.
`timescale 1ns / 1ps
package cbpe_pkg;

  // Default configuration of the block.
  localparam int STEP_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 16;

  // Configuration port.
  localparam int CP_BITS      = 48;
  localparam int CFG_IDX_BITS = 3;
  localparam int TESS_RESET   = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_CP0  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP1  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP2  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP3  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TESS = 3'd4;

  // Curve parameter t is unsigned with FRAC_BITS fraction bits and one integer bit.
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_ONE   = 65536;
  localparam int ROUND_HALF = 32768;

  // Divider: quotient bits produced in total and per pipeline stage.
  localparam int DIV_Q_BITS         = 18;
  localparam int DIV_BITS_PER_STAGE = 3;
  localparam int DIV_STAGES         = DIV_Q_BITS / DIV_BITS_PER_STAGE;

  // Horner evaluator: a multiply stage and a round/add stage per coefficient.
  localparam int HORNER_STAGES = 6;

  // Headroom over the coordinate width for coefficients and the accumulator.
  localparam int COEF_GROWTH = 4;
  localparam int ACC_GROWTH  = 5;

endpackage

>>> rtl/cubic_bezier_point_evaluator.sv
// Top level of the cubic Bezier point evaluator.
`timescale 1ns / 1ps
`include "cubic_bezier_point_evaluator_macros.svh"
// The block evaluates a 3-D cubic Bezier curve at step t = i/N, where i is the
// step_index of an input item and N is the tess_level register (zero acts as one).
// A step index above N is clamped to N and the result is flagged in step_clamped.
// Control points are packed x, y, z in signed Q8.8; the power-basis coefficients
// are registered from them behind the control point registers, so configuration
// must only be written while no item is in flight. The datapath is a fully
// pipelined chain: one clamp stage, a six-stage divider that delivers three
// quotient bits per stage to form t in Q1.16 with round-to-nearest, and six Horner
// stages (multiply, then round and add, for each of the three coefficients a, b
// and c), followed by saturation into the output register. One item is accepted in
// every cycle while the output side takes results. The whole pipeline advances
// together: when a result waits at the output, every stage holds, so nothing is
// lost or repeated, and in_ready_o is low only while the output item is stalled.
module cubic_bezier_point_evaluator #(
  parameter int STEP_BITS  = cbpe_pkg::STEP_BITS_DEF,
  parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [cbpe_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [cbpe_pkg::CP_BITS-1:0]         cfg_data_i,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [STEP_BITS-1:0]                 step_index_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_BITS-1:0]         point_x_o,
  output logic signed [COORD_BITS-1:0]         point_y_o,
  output logic signed [COORD_BITS-1:0]         point_z_o,
  output logic                                 step_clamped_o
);

  localparam int CP_BITS   = cbpe_pkg::CP_BITS;
  localparam int EXT_BITS  = (3 * COORD_BITS > CP_BITS) ? 3 * COORD_BITS : CP_BITS;
  localparam int COEF_BITS = COORD_BITS + cbpe_pkg::COEF_GROWTH;
  localparam int ACC_BITS  = COORD_BITS + cbpe_pkg::ACC_GROWTH;
  localparam int NUM_BITS  = STEP_BITS + cbpe_pkg::FRAC_BITS + 1;
  localparam int QB        = cbpe_pkg::DIV_Q_BITS;
  localparam int LAT       = 1 + cbpe_pkg::DIV_STAGES + cbpe_pkg::HORNER_STAGES;
  localparam int DIV_OUT   = cbpe_pkg::DIV_STAGES;

  localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [CP_BITS-1:0]   cp_q [4];
  logic [STEP_BITS-1:0] tess_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        cp_q[k] <= '0;
      end
      tess_q <= STEP_BITS'(cbpe_pkg::TESS_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cbpe_pkg::REG_CP0:  cp_q[0] <= cfg_data_i;
        cbpe_pkg::REG_CP1:  cp_q[1] <= cfg_data_i;
        cbpe_pkg::REG_CP2:  cp_q[2] <= cfg_data_i;
        cbpe_pkg::REG_CP3:  cp_q[3] <= cfg_data_i;
        cbpe_pkg::REG_TESS: tess_q  <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Power-basis coefficients, rebuilt from the control points every cycle.
  // Bits above the 48-bit register read as zero for wide coordinates.
  // ---------------------------------------------------------------------------
  logic [EXT_BITS-1:0]         cp_wide [4];
  logic signed [COEF_BITS-1:0] coef_q [3][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cp_wide[k] = EXT_BITS'(cp_q[k]);
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_coef
    logic signed [COEF_BITS-1:0] p0, p1, p2, p3;
    logic signed [COEF_BITS-1:0] a_d, b_d, c_d;

    assign p0 = COEF_BITS'($signed(cp_wide[0][ax*COORD_BITS +: COORD_BITS]));
    assign p1 = COEF_BITS'($signed(cp_wide[1][ax*COORD_BITS +: COORD_BITS]));
    assign p2 = COEF_BITS'($signed(cp_wide[2][ax*COORD_BITS +: COORD_BITS]));
    assign p3 = COEF_BITS'($signed(cp_wide[3][ax*COORD_BITS +: COORD_BITS]));

    // a = -P0 + 3P1 - 3P2 + P3, b = 3P0 - 6P1 + 3P2, c = 3P1 - 3P0.
    always_comb begin
      a_d = (p1 + (p1 <<< 1)) - (p2 + (p2 <<< 1)) + p3 - p0;
      b_d = (p0 + (p0 <<< 1)) + (p2 + (p2 <<< 1)) - ((p1 <<< 2) + (p1 <<< 1));
      c_d = (p1 + (p1 <<< 1)) - (p0 + (p0 <<< 1));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[ax][0] <= '0;
        coef_q[ax][1] <= '0;
        coef_q[ax][2] <= '0;
        coef_q[ax][3] <= '0;
      end else begin
        coef_q[ax][0] <= a_d;
        coef_q[ax][1] <= b_d;
        coef_q[ax][2] <= c_d;
        coef_q[ax][3] <= p0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage advances together whenever the output
  // register is empty or its item is being taken.
  // ---------------------------------------------------------------------------
  logic           adv;
  logic [LAT-1:0] vld_q, vld_d;
  logic [LAT-1:0] clamp_q, clamp_d;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: clamp the step index and build the divider numerator
  // i * 2^16 + floor(N / 2), which makes the quotient round to nearest.
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0] n_eff;
  logic [STEP_BITS-1:0] i_sel;
  logic                 over;
  logic [NUM_BITS-1:0]  num_d, num_q;

  always_comb begin
    n_eff = (tess_q == '0) ? STEP_BITS'(1) : tess_q;
    over  = step_index_i > n_eff;
    i_sel = over ? n_eff : step_index_i;
    num_d = NUM_BITS'({i_sel, {cbpe_pkg::FRAC_BITS{1'b0}}}) + NUM_BITS'(n_eff >> 1);
  end

  always_comb begin
    vld_d   = {vld_q[LAT-2:0], in_valid_i};
    clamp_d = {clamp_q[LAT-2:0], over};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clamp_q <= clamp_d;
      num_q   <= num_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: t = floor((i * 2^16 + floor(N / 2)) / N), 0 to 2^16.
  // ---------------------------------------------------------------------------
  logic [QB-1:0]                  quo_w;
  logic [cbpe_pkg::FRAC_BITS:0]   t_w;

  cbpe_div #(
    .STEP_BITS (STEP_BITS)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_q),
    .den_i (n_eff),
    .quo_o (quo_w)
  );

  assign t_w = quo_w[cbpe_pkg::FRAC_BITS:0];

  // ---------------------------------------------------------------------------
  // Horner stages, one evaluator per axis, and saturation into the output.
  // ---------------------------------------------------------------------------
  logic signed [ACC_BITS-1:0]   acc_w [3];
  logic signed [COORD_BITS-1:0] pt_d [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    cbpe_horner #(
      .COORD_BITS (COORD_BITS)
    ) u_horner (
      .clk_i    (clk_i),
      .en_i     (adv),
      .t_i      (t_w),
      .coef_a_i (coef_q[ax][0]),
      .coef_b_i (coef_q[ax][1]),
      .coef_c_i (coef_q[ax][2]),
      .coef_d_i (coef_q[ax][3]),
      .acc_o    (acc_w[ax])
    );

    always_comb begin
      if (acc_w[ax] > SAT_HI) begin
        pt_d[ax] = SAT_HI[COORD_BITS-1:0];
      end else if (acc_w[ax] < SAT_LO) begin
        pt_d[ax] = SAT_LO[COORD_BITS-1:0];
      end else begin
        pt_d[ax] = acc_w[ax][COORD_BITS-1:0];
      end
    end
  end

  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] pt_q [3];
  logic                         clamp_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[0]     <= pt_d[0];
      pt_q[1]     <= pt_d[1];
      pt_q[2]     <= pt_d[2];
      clamp_out_q <= clamp_q[LAT-1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];
  assign step_clamped_o = clamp_out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An accepted item must occupy the first stage on the next cycle.
  `CBPE_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0], "accepted item lost at stage 0")
  // A stalled output freezes the whole valid chain.
  `CBPE_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i, $stable(vld_q), "pipeline moved during stall")
  // With the step clamped to N, the divider never returns more than one.
  `CBPE_ASSERT_IMPL(a_t_range, vld_q[DIV_OUT], quo_w <= QB'(cbpe_pkg::FRAC_ONE), "t exceeds one")

endmodule

>>> rtl/cbpe_div.sv
// Pipelined restoring divider that turns a step index into the curve parameter t.
`timescale 1ns / 1ps
module cbpe_div #(
  parameter int STEP_BITS = cbpe_pkg::STEP_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic [STEP_BITS+cbpe_pkg::FRAC_BITS:0]      num_i,
  input  logic [STEP_BITS-1:0]                        den_i,
  output logic [cbpe_pkg::DIV_Q_BITS-1:0]             quo_o
);

  localparam int QB       = cbpe_pkg::DIV_Q_BITS;
  localparam int BPS      = cbpe_pkg::DIV_BITS_PER_STAGE;
  localparam int NSTG     = cbpe_pkg::DIV_STAGES;
  localparam int NUM_BITS = STEP_BITS + cbpe_pkg::FRAC_BITS + 1;
  localparam int REM_BITS = STEP_BITS;

  logic [REM_BITS-1:0] rem_q [NSTG];
  logic [QB-1:0]       low_q [NSTG];
  logic [QB-1:0]       quo_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [REM_BITS-1:0] rem_in;
    logic [QB-1:0]       low_in;
    logic [QB-1:0]       quo_in;
    logic [REM_BITS-1:0] rem_d;
    logic [QB-1:0]       low_d;
    logic [QB-1:0]       quo_d;

    if (s == 0) begin : g_first
      // The numerator bits above the quotient field are always below the divisor.
      assign rem_in = REM_BITS'(num_i[NUM_BITS-1:QB]);
      assign low_in = num_i[QB-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [REM_BITS:0] r_v;
      logic [QB-1:0]     l_v;
      logic [QB-1:0]     q_v;
      r_v = {1'b0, rem_in};
      l_v = low_in;
      q_v = quo_in;
      for (int b = 0; b < BPS; b++) begin
        r_v = {r_v[REM_BITS-1:0], l_v[QB-1]};
        l_v = {l_v[QB-2:0], 1'b0};
        if (r_v >= {1'b0, den_i}) begin
          r_v = r_v - {1'b0, den_i};
          q_v = {q_v[QB-2:0], 1'b1};
        end else begin
          q_v = {q_v[QB-2:0], 1'b0};
        end
      end
      rem_d = r_v[REM_BITS-1:0];
      low_d = l_v;
      quo_d = q_v;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[NSTG-1];

endmodule

>>> rtl/cbpe_horner.sv
// Pipelined Horner evaluation of one axis of the cubic polynomial.
`timescale 1ns / 1ps
module cbpe_horner #(
  parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic        [cbpe_pkg::FRAC_BITS:0]                  t_i,
  input  logic signed [COORD_BITS+cbpe_pkg::COEF_GROWTH-1:0]   coef_a_i,
  input  logic signed [COORD_BITS+cbpe_pkg::COEF_GROWTH-1:0]   coef_b_i,
  input  logic signed [COORD_BITS+cbpe_pkg::COEF_GROWTH-1:0]   coef_c_i,
  input  logic signed [COORD_BITS+cbpe_pkg::COEF_GROWTH-1:0]   coef_d_i,
  output logic signed [COORD_BITS+cbpe_pkg::ACC_GROWTH-1:0]    acc_o
);

  localparam int T_BITS    = cbpe_pkg::FRAC_BITS + 1;
  localparam int ACC_BITS  = COORD_BITS + cbpe_pkg::ACC_GROWTH;
  localparam int PROD_BITS = ACC_BITS + T_BITS + 1;

  localparam logic signed [PROD_BITS-1:0] RND = PROD_BITS'(cbpe_pkg::ROUND_HALF);

  logic signed [T_BITS:0]      t_s;
  logic signed [ACC_BITS-1:0]  a_ext;
  logic signed [PROD_BITS-1:0] prod1_d, prod2_d, prod3_d;
  logic signed [PROD_BITS-1:0] prod1_q, prod2_q, prod3_q;
  logic signed [PROD_BITS-1:0] rnd1, rnd2, rnd3;
  logic signed [ACC_BITS-1:0]  acc1_d, acc2_d, acc3_d;
  logic signed [ACC_BITS-1:0]  acc1_q, acc2_q, acc3_q;
  logic        [T_BITS-1:0]    t1_q, t2_q, t3_q, t4_q;

  // t travels beside the accumulator so each multiply uses its own item's t.
  assign t_s   = $signed({1'b0, t_i});
  assign a_ext = ACC_BITS'(coef_a_i);

  always_comb begin
    prod1_d = a_ext * t_s;
    rnd1    = (prod1_q + RND) >>> cbpe_pkg::FRAC_BITS;
    acc1_d  = ACC_BITS'(rnd1) + ACC_BITS'(coef_b_i);
    prod2_d = acc1_q * $signed({1'b0, t2_q});
    rnd2    = (prod2_q + RND) >>> cbpe_pkg::FRAC_BITS;
    acc2_d  = ACC_BITS'(rnd2) + ACC_BITS'(coef_c_i);
    prod3_d = acc2_q * $signed({1'b0, t4_q});
    rnd3    = (prod3_q + RND) >>> cbpe_pkg::FRAC_BITS;
    acc3_d  = ACC_BITS'(rnd3) + ACC_BITS'(coef_d_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      t1_q    <= t_i;
      acc1_q  <= acc1_d;
      t2_q    <= t1_q;
      prod2_q <= prod2_d;
      t3_q    <= t2_q;
      acc2_q  <= acc2_d;
      t4_q    <= t3_q;
      prod3_q <= prod3_d;
      acc3_q  <= acc3_d;
    end
  end

  assign acc_o = acc3_q;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the cubic Bezier point evaluator.
`timescale 1ns / 1ps
// The bench drives step indexes into the evaluator and checks every result against a
// known point or its own fixed-point model of the curve. It keeps its own copy of the
// control points, the segment count and the power-basis coefficients. It works out t
// and runs the Horner evaluation with the same rounding and saturation as the block.
// The run starts with a directed table and then a burst that backs the pipeline up.
// Random phases follow, each with fresh configuration and its own idling mix.
// Configuration is only written once every pending result has come back.
module tb_top;
  import cbpe_pkg::*;

  localparam int STEP_W = STEP_BITS_DEF;
  localparam int CW     = COORD_BITS_DEF;

  localparam int LATENCY         = 14;
  localparam int SETTLE_CYCLES   = 2 * LATENCY;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int BURST_ITEMS     = 40;
  localparam int HOLD_CYCLES     = 100;
  localparam int MAX_SHOWN       = 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clamped;
  } curve_point_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_STEP,
    ROW_STEP_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [CP_BITS-1:0]      data;
    logic [STEP_W-1:0]       step;
    curve_point_t            known;
  } stim_row_t;

  // Control points for the directed part, packed z, y, x. The x and y coordinates sit
  // at the extremes of the signed range.
  localparam logic [CP_BITS-1:0] CP_START    = {16'h0000, 16'h8000, 16'h7FFF};
  localparam logic [CP_BITS-1:0] CP_HANDLE_A = {16'h1234, 16'h7FFF, 16'h8000};
  localparam logic [CP_BITS-1:0] CP_HANDLE_B = {16'hEDCC, 16'h8000, 16'h7FFF};
  localparam logic [CP_BITS-1:0] CP_END      = {16'hFFFF, 16'h7FFF, 16'h8000};

  // At t = 0 the curve is exactly the start point. At t = 1.0 it is exactly the end point.
  localparam curve_point_t ORIGIN         = '0;
  localparam curve_point_t ORIGIN_CLAMPED = {16'h0000, 16'h0000, 16'h0000, 1'b1};
  localparam curve_point_t START_PT       = {16'h7FFF, 16'h8000, 16'h0000, 1'b0};
  localparam curve_point_t END_PT         = {16'h8000, 16'h7FFF, 16'hFFFF, 1'b0};
  localparam curve_point_t END_CLAMPED    = {16'h8000, 16'h7FFF, 16'hFFFF, 1'b1};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CP_BITS-1:0]      cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [STEP_W-1:0]       step_index;
  logic                    out_valid;
  logic                    out_ready;
  coord_t                  point_x;
  coord_t                  point_y;
  coord_t                  point_z;
  logic                    step_clamped;

  // Idling mix of the current phase, in percent of cycles.
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  // A nonzero value asks the receiver process to hold off for that many cycles.
  int rx_hold_cycles = 0;
  int mismatch_count = 0;

  // Points still owed by the block, oldest first.
  curve_point_t pending_points[$];

  // Configuration as the block should hold it, with the derived coefficients.
  logic [CP_BITS-1:0] ctrl_pts [4];
  logic [STEP_W-1:0]  seg_count;
  longint             basis [4][3];  // [a, b, c, d][x, y, z]

  cubic_bezier_point_evaluator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .step_index_i   (step_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .point_z_o      (point_z),
    .step_clamped_o (step_clamped)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous upper bound on the run. A correct run finishes far earlier than this.
  initial begin
    #400_000;
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Curve model
  // ---------------------------------------------------------------------------

  function automatic longint axis_coord(logic [CP_BITS-1:0] pt, int ax);
    coord_t c;
    c = pt[ax*CW +: CW];
    return longint'(c);
  endfunction

  // The power-basis coefficients are exact integer combinations of the control points.
  // Their growth stays well inside 64 bits.
  function automatic void rebuild_basis();
    int     ax;
    longint p0, p1, p2, p3;
    for (ax = 0; ax < 3; ax++) begin
      p0 = axis_coord(ctrl_pts[0], ax);
      p1 = axis_coord(ctrl_pts[1], ax);
      p2 = axis_coord(ctrl_pts[2], ax);
      p3 = axis_coord(ctrl_pts[3], ax);
      basis[0][ax] = -p0 + 3 * p1 - 3 * p2 + p3;
      basis[1][ax] = 3 * p0 - 6 * p1 + 3 * p2;
      basis[2][ax] = -3 * p0 + 3 * p1;
      basis[3][ax] = p0;
    end
  endfunction

  function automatic curve_point_t eval_curve_point(logic [STEP_W-1:0] idx);
    longint       n, i, t, acc, hi, lo;
    int           ax, k;
    coord_t       res [3];
    curve_point_t pt;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    // A segment count of zero behaves as one.
    n = seg_count;
    if (n == 0) n = 1;
    i = idx;
    pt.clamped = 1'b0;
    if (i > n) begin
      i = n;
      pt.clamped = 1'b1;
    end
    // t in Q1.16 with one integer bit, rounded to nearest, so i == n gives exactly 1.0.
    t = (i * FRAC_ONE + n / 2) / n;
    for (ax = 0; ax < 3; ax++) begin
      acc = basis[0][ax];
      // Each product is rounded half up by an arithmetic shift, which floors.
      for (k = 1; k < 4; k++) begin
        acc = ((acc * t + ROUND_HALF) >>> FRAC_BITS) + basis[k][ax];
      end
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
      res[ax] = acc[CW-1:0];
    end
    pt.x = res[0];
    pt.y = res[1];
    pt.z = res[2];
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t write_row(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CP_BITS-1:0] data);
    stim_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.data    = data;
    r.step    = '0;
    r.known   = '0;
    return r;
  endfunction

  function automatic stim_row_t step_row(logic [STEP_W-1:0] step);
    stim_row_t r;
    r         = write_row(REG_CP0, '0);
    r.kind    = ROW_STEP;
    r.step    = step;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [STEP_W-1:0] step, curve_point_t pt);
    stim_row_t r;
    r       = step_row(step);
    r.kind  = ROW_STEP_KNOWN;
    r.known = pt;
    return r;
  endfunction

  // Mostly small coordinates that keep the curve in range, with the two extremes and
  // fully random values mixed in to drive the saturation.
  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(9))
      0:       c = {1'b0, {(CW-1){1'b1}}};
      1:       c = {1'b1, {(CW-1){1'b0}}};
      2, 3:    c = coord_t'($urandom);
      default: c = coord_t'($urandom_range(2047)) - coord_t'(1024);
    endcase
    return c;
  endfunction

  // Most steps lie within the curve. The rest use the whole field and may get clamped.
  function automatic logic [STEP_W-1:0] rand_step();
    int n;
    n = (seg_count == 0) ? 1 : int'(seg_count);
    if ($urandom_range(99) < 85) return STEP_W'($urandom_range(n));
    return STEP_W'($urandom);
  endfunction

  // The write enable is raised for one cycle per write. It is lowered by the next action
  // that is not a write, so that back-to-back writes never lower and raise it in one step.
  task automatic close_writes();
    if (cfg_we) cfg_we <= 1'b0;
  endtask

  // Registers are written only once every pending result has come back.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CP_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CP0, REG_CP1, REG_CP2, REG_CP3: begin
        ctrl_pts[idx[1:0]] = data;
        rebuild_basis();
      end
      REG_TESS: seg_count = data[STEP_W-1:0];
      default: ;  // Unused indexes leave the configuration alone.
    endcase
    @(posedge clk_i);
  endtask

  // Offers one item and returns at the edge that accepts it. Valid stays high on return.
  // The next offer either replaces the payload at once or idles first.
  task automatic offer(input logic [STEP_W-1:0] idx, input bit known, input curve_point_t pt);
    close_writes();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    step_index <= idx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_points.insert(pending_points.size(), known ? pt : eval_curve_point(idx));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs on request, counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Each accepted result is compared with the oldest pending point.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    curve_point_t want, got;
    if (rst_ni && out_valid && out_ready) begin
      got = {point_x, point_y, point_z, step_clamped};
      if (pending_points.size() == 0) begin
        if (mismatch_count < MAX_SHOWN) begin
          $display("%0t: unexpected point x=%0d y=%0d z=%0d clamped=%0b",
                   $time, got.x, got.y, got.z, got.clamped);
        end
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.clamped !== want.clamped) begin
          if (mismatch_count < MAX_SHOWN) begin
            $display("%0t: point mismatch, expected x=%0d y=%0d z=%0d clamped=%0b",
                     $time, want.x, want.y, want.z, want.clamped);
            $display("%0t:                 actual   x=%0d y=%0d z=%0d clamped=%0b",
                     $time, got.x, got.y, got.z, got.clamped);
          end
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t          rows[$];
    logic [CP_BITS-1:0] data;
    int                 spare, ph, c, tess;

    rst_ni     <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    step_index <= '0;

    // After reset the control points are zero and the curve has 16 segments.
    foreach (ctrl_pts[c]) ctrl_pts[c] = '0;
    seg_count = STEP_W'(TESS_RESET);
    rebuild_basis();

    // Directed table. With all control points at zero every step gives the origin.
    rows.insert(rows.size(), known_row(STEP_W'(0), ORIGIN));
    rows.insert(rows.size(), known_row(STEP_W'(16), ORIGIN));
    rows.insert(rows.size(), known_row(STEP_W'(17), ORIGIN_CLAMPED));
    rows.insert(rows.size(), known_row('1, ORIGIN_CLAMPED));
    // Extreme control points. The ends are exact, and the middle is checked against the model.
    rows.insert(rows.size(), write_row(REG_CP0, CP_START));
    rows.insert(rows.size(), write_row(REG_CP1, CP_HANDLE_A));
    rows.insert(rows.size(), write_row(REG_CP2, CP_HANDLE_B));
    rows.insert(rows.size(), write_row(REG_CP3, CP_END));
    rows.insert(rows.size(), known_row(STEP_W'(0), START_PT));
    rows.insert(rows.size(), known_row(STEP_W'(16), END_PT));
    rows.insert(rows.size(), step_row(STEP_W'(8)));
    rows.insert(rows.size(), step_row(STEP_W'(5)));
    rows.insert(rows.size(), step_row(STEP_W'(13)));
    rows.insert(rows.size(), known_row(STEP_W'(20), END_CLAMPED));
    // A segment count of zero acts as a single segment.
    rows.insert(rows.size(), write_row(REG_TESS, '0));
    rows.insert(rows.size(), known_row(STEP_W'(0), START_PT));
    rows.insert(rows.size(), known_row(STEP_W'(1), END_PT));
    rows.insert(rows.size(), known_row(STEP_W'(2), END_CLAMPED));
    rows.insert(rows.size(), known_row('1, END_CLAMPED));
    // All-ones data sets the largest segment count. The upper bits must be dropped.
    rows.insert(rows.size(), write_row(REG_TESS, '1));
    rows.insert(rows.size(), known_row(STEP_W'(0), START_PT));
    rows.insert(rows.size(), known_row('1, END_PT));
    rows.insert(rows.size(), step_row(STEP_W'(1)));
    rows.insert(rows.size(), step_row(STEP_W'(511)));
    rows.insert(rows.size(), step_row(STEP_W'(512)));
    // Three segments make t inexact, so the rounding of t matters here.
    rows.insert(rows.size(), write_row(REG_TESS, CP_BITS'(3)));
    rows.insert(rows.size(), step_row(STEP_W'(1)));
    rows.insert(rows.size(), step_row(STEP_W'(2)));
    // Writes to the unused indexes must change nothing.
    for (spare = int'(REG_TESS) + 1; spare < (1 << CFG_IDX_BITS); spare++) begin
      rows.insert(rows.size(), write_row(CFG_IDX_BITS'(spare), '1));
    end
    rows.insert(rows.size(), known_row(STEP_W'(3), END_PT));
    rows.insert(rows.size(), known_row(STEP_W'(0), START_PT));
    rows.insert(rows.size(), known_row(STEP_W'(9), END_CLAMPED));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[c]) begin
      case (rows[c].kind)
        ROW_WRITE:      write_reg(rows[c].reg_idx, rows[c].data);
        ROW_STEP:       offer(rows[c].step, 1'b0, '0);
        ROW_STEP_KNOWN: offer(rows[c].step, 1'b1, rows[c].known);
        default: ;
      endcase
    end

    // The receiver holds off for a long stretch while the sender keeps offering.
    // The pipeline fills, and the input side has to stall until results drain.
    rx_hold_cycles = HOLD_CYCLES;
    repeat (BURST_ITEMS) offer(rand_step(), 1'b0, '0);

    // Random phases. Each phase waits for all pending results and then reconfigures.
    // The first phases pin the segment count to its extremes.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      case (ph)
        0:       tess = 1;
        1:       tess = (1 << STEP_W) - 1;
        2:       tess = 0;
        default: tess = ($urandom_range(9) < 7) ? $urandom_range(40, 1)
                                                : $urandom_range((1 << STEP_W) - 1);
      endcase
      data = CP_BITS'({$urandom, $urandom});
      data[STEP_W-1:0] = STEP_W'(tess);
      write_reg(REG_TESS, data);
      // Some phases keep a few old control points, so a segment-count write alone is also tried.
      for (c = 0; c < 4; c++) begin
        if (ph < 2 || $urandom_range(9) < 7) begin
          write_reg(REG_CP0 + CFG_IDX_BITS'(c), {rand_coord(), rand_coord(), rand_coord()});
        end
      end
      repeat (ITEMS_PER_PHASE) offer(rand_step(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    // Any stray result after the last expected one is caught by the checker here.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
